// File: src/touch_contact_tracker_core_defines.svh
// Assertion macros for the checker file of the contact tracker.
`ifndef TOUCH_CONTACT_TRACKER_CORE_DEFINES_SVH
`define TOUCH_CONTACT_TRACKER_CORE_DEFINES_SVH

// Next-cycle implication, switched off while reset is held.
`define TCT_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

// Next-cycle implication that also holds through reset.
`define TCT_ASSERT_NEXT_ALWAYS(label, clk, ante, cons, msg) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) else $error(msg);

`endif

// File: src/tct_pkg.sv
package tct_pkg;

  localparam int unsigned CONTACT_SLOTS_DEF = 256;

  localparam int ID_W      = 8;
  localparam int COORD_W   = 16;
  localparam int WIN_W     = 16;
  localparam int DEV_W     = 15;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_W     = 16;

  // Serial arithmetic: magnitude of a raw coordinate, full product width and
  // the number of steps of the shift-add multiply and restoring divide.
  localparam int MAG_W      = COORD_W + 1;
  localparam int PROD_W     = MAG_W + WIN_W;
  localparam int MUL_STEPS  = WIN_W;
  localparam int DIV_STEPS  = PROD_W;
  localparam int STEP_CNT_W = $clog2(DIV_STEPS);

  localparam logic [WIN_W-1:0]          WINDOW_WIDTH_RST  = WIN_W'(1920);
  localparam logic [WIN_W-1:0]          WINDOW_HEIGHT_RST = WIN_W'(1080);
  localparam logic [DEV_W-1:0]          DEVICE_WIDTH_RST  = DEV_W'(32767);
  localparam logic [DEV_W-1:0]          DEVICE_HEIGHT_RST = DEV_W'(32767);
  localparam logic signed [COORD_W-1:0] ORIGIN_RST        = '0;

  typedef enum logic [1:0] {
    TS_PRESSED  = 2'd0,
    TS_MOVED    = 2'd1,
    TS_RELEASED = 2'd2
  } touch_state_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_WINDOW_WIDTH  = 3'd0,
    CFG_WINDOW_HEIGHT = 3'd1,
    CFG_DEVICE_WIDTH  = 3'd2,
    CFG_DEVICE_HEIGHT = 3'd3,
    CFG_ORIGIN_X      = 3'd4,
    CFG_ORIGIN_Y      = 3'd5
  } cfg_index_t;

  typedef struct packed {
    logic busy;
    logic done;
  } unit_status_t;

endpackage

// File: src/tct_coord_unit.sv
// Bit-serial coordinate mapper: shift-add multiply of |raw| by the window
// size, restoring divide by the device size, then sign and origin fix-up.
module tct_coord_unit (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   start,
  input  logic signed [tct_pkg::COORD_W-1:0]     raw,
  input  logic        [tct_pkg::WIN_W-1:0]       win,
  input  logic        [tct_pkg::DEV_W-1:0]       dev,
  input  logic signed [tct_pkg::COORD_W-1:0]     org,
  output logic signed [tct_pkg::COORD_W-1:0]     result,
  output tct_pkg::unit_status_t                  status
);

  typedef enum logic [1:0] {U_IDLE, U_MUL, U_DIV, U_FIN} ustate_t;

  ustate_t                              state_r;
  logic [tct_pkg::STEP_CNT_W-1:0]       cnt_r;
  logic                                 done_r;
  logic [tct_pkg::MAG_W-1:0]            mag_r;
  logic                                 neg_r;
  logic [tct_pkg::PROD_W-1:0]           prod_r;
  logic [tct_pkg::DEV_W-1:0]            rem_r;
  logic [tct_pkg::COORD_W-1:0]          quo_r;
  logic [tct_pkg::DEV_W-1:0]            dev_r;
  logic signed [tct_pkg::COORD_W-1:0]   org_r;
  logic signed [tct_pkg::COORD_W-1:0]   res_r;

  logic signed [tct_pkg::MAG_W-1:0]     raw_ext;
  logic [tct_pkg::MAG_W-1:0]            mag_in;
  logic [tct_pkg::MAG_W:0]              mul_sum;
  logic [tct_pkg::DEV_W:0]              div_try;
  logic [tct_pkg::DEV_W:0]              div_diff;
  logic                                 div_ge;
  logic [tct_pkg::COORD_W-1:0]          scaled;

  assign raw_ext = {raw[tct_pkg::COORD_W-1], raw};
  assign mag_in  = raw[tct_pkg::COORD_W-1] ? tct_pkg::MAG_W'(-raw_ext)
                                           : tct_pkg::MAG_W'(raw_ext);

  // One multiplier bit per cycle, least significant first; the high half
  // accumulates while the whole product shifts right.
  assign mul_sum = {1'b0, prod_r[tct_pkg::PROD_W-1:tct_pkg::WIN_W]}
                 + (prod_r[0] ? {1'b0, mag_r} : '0);

  // One quotient bit per cycle, dividend bits taken from the top.
  assign div_try  = {rem_r, prod_r[tct_pkg::PROD_W-1]};
  assign div_ge   = div_try >= {1'b0, dev_r};
  assign div_diff = div_try - {1'b0, dev_r};

  // Only the low bits of the quotient survive the final wrap.
  assign scaled = (dev_r == '0) ? '0 : (neg_r ? (~quo_r + 1'b1) : quo_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= U_IDLE;
      cnt_r   <= '0;
      done_r  <= 1'b0;
    end else begin
      done_r <= 1'b0;
      case (state_r)
        U_IDLE: begin
          if (start) begin
            mag_r   <= mag_in;
            neg_r   <= raw[tct_pkg::COORD_W-1];
            prod_r  <= {{tct_pkg::MAG_W{1'b0}}, win};
            dev_r   <= dev;
            org_r   <= org;
            cnt_r   <= '0;
            state_r <= U_MUL;
          end
        end
        U_MUL: begin
          prod_r <= {mul_sum, prod_r[tct_pkg::WIN_W-1:1]};
          if (cnt_r == tct_pkg::STEP_CNT_W'(tct_pkg::MUL_STEPS - 1)) begin
            cnt_r   <= '0;
            rem_r   <= '0;
            quo_r   <= '0;
            state_r <= U_DIV;
          end else begin
            cnt_r <= cnt_r + 1'b1;
          end
        end
        U_DIV: begin
          rem_r  <= div_ge ? div_diff[tct_pkg::DEV_W-1:0] : div_try[tct_pkg::DEV_W-1:0];
          quo_r  <= {quo_r[tct_pkg::COORD_W-2:0], div_ge};
          prod_r <= {prod_r[tct_pkg::PROD_W-2:0], 1'b0};
          if (cnt_r == tct_pkg::STEP_CNT_W'(tct_pkg::DIV_STEPS - 1)) begin
            cnt_r   <= '0;
            state_r <= U_FIN;
          end else begin
            cnt_r <= cnt_r + 1'b1;
          end
        end
        U_FIN: begin
          res_r   <= $signed(scaled) - org_r;
          done_r  <= 1'b1;
          state_r <= U_IDLE;
        end
        default: state_r <= U_IDLE;
      endcase
    end
  end

  assign result      = res_r;
  assign status.busy = (state_r != U_IDLE);
  assign status.done = done_r;

endmodule

// File: src/tct_contact_table.sv
// Per-contact state table: folds the id onto a slot by repeated subtraction,
// reads the stored state, applies the touch transition and writes it back.
module tct_contact_table #(
  parameter int unsigned CONTACT_SLOTS = tct_pkg::CONTACT_SLOTS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic [tct_pkg::ID_W-1:0]      finger_id,
  input  logic                          tip_down,
  output tct_pkg::touch_state_t         touch_state,
  output tct_pkg::unit_status_t         status
);

  localparam int SLOT_W = $clog2(CONTACT_SLOTS);

  typedef enum logic [1:0] {T_IDLE, T_REDUCE, T_UPDATE} tstate_t;

  tstate_t                     state_r;
  logic                        done_r;
  logic [tct_pkg::ID_W-1:0]    slot_r;
  logic                        tip_r;
  logic                        rd_known_r;
  tct_pkg::touch_state_t       rd_state_r;
  tct_pkg::touch_state_t       new_state_r;
  logic [CONTACT_SLOTS-1:0]    known_r;
  tct_pkg::touch_state_t       state_mem [CONTACT_SLOTS];

  logic                        slot_ge;
  logic [SLOT_W-1:0]           slot_idx;
  logic                        rd_en;
  logic                        wr_en;
  tct_pkg::touch_state_t       upd_state;

  assign slot_ge  = {1'b0, slot_r} >= (tct_pkg::ID_W + 1)'(CONTACT_SLOTS);
  assign slot_idx = slot_r[SLOT_W-1:0];
  assign rd_en    = (state_r == T_REDUCE) && !slot_ge;
  assign wr_en    = (state_r == T_UPDATE);

  always_comb begin
    if (!tip_r) begin
      upd_state = tct_pkg::TS_RELEASED;
    end else if (!rd_known_r) begin
      upd_state = tct_pkg::TS_PRESSED;
    end else begin
      case (rd_state_r)
        tct_pkg::TS_PRESSED:  upd_state = tct_pkg::TS_MOVED;
        tct_pkg::TS_RELEASED: upd_state = tct_pkg::TS_PRESSED;
        default:              upd_state = tct_pkg::TS_MOVED;
      endcase
    end
  end

  // State store; an entry is only trusted once its known flag is set.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      state_mem[slot_idx] <= upd_state;
    end
    if (rd_en) begin
      rd_state_r <= state_mem[slot_idx];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      known_r <= '0;
    end else if (wr_en) begin
      known_r[slot_idx] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= T_IDLE;
      done_r  <= 1'b0;
    end else begin
      done_r <= 1'b0;
      case (state_r)
        T_IDLE: begin
          if (start) begin
            slot_r  <= finger_id;
            tip_r   <= tip_down;
            state_r <= T_REDUCE;
          end
        end
        T_REDUCE: begin
          if (slot_ge) begin
            slot_r <= slot_r - tct_pkg::ID_W'(CONTACT_SLOTS);
          end else begin
            rd_known_r <= known_r[slot_idx];
            state_r    <= T_UPDATE;
          end
        end
        T_UPDATE: begin
          new_state_r <= upd_state;
          done_r      <= 1'b1;
          state_r     <= T_IDLE;
        end
        default: state_r <= T_IDLE;
      endcase
    end
  end

  assign touch_state = new_state_r;
  assign status.busy = (state_r != T_IDLE);
  assign status.done = done_r;

endmodule

// File: src/touch_contact_tracker_core.sv
// Flow: one beat at a time. Each beat runs the bit-serial multiply (16 steps)
// and restoring divide (33 steps) in each coordinate unit before the next beat
// is taken; a waiting result does not block the next input beat until that
// beat's own result is ready.
// Reset: synchronous, active low; clears control state, the contact known
// flags and restores every configuration register to its default.
module touch_contact_tracker_core #(
  parameter int unsigned CONTACT_SLOTS = tct_pkg::CONTACT_SLOTS_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst_n,

  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic        [tct_pkg::ID_W-1:0]      in_contact_id,
  input  logic                                 in_tip_down,
  input  logic signed [tct_pkg::COORD_W-1:0]   in_x_raw,
  input  logic signed [tct_pkg::COORD_W-1:0]   in_y_raw,

  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic        [tct_pkg::ID_W-1:0]      out_point_id,
  output logic        [1:0]                    out_touch_state,
  output logic signed [tct_pkg::COORD_W-1:0]   out_pos_x,
  output logic signed [tct_pkg::COORD_W-1:0]   out_pos_y,

  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic        [tct_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic        [tct_pkg::CFG_W-1:0]     cfg_data
);

  // The engine either waits for a beat, runs the three serial units, or holds
  // a finished result until the output register is free to take it.
  typedef enum logic [1:0] {S_IDLE, S_RUN, S_HOLD} state_t;

  state_t                              state_r;
  logic                                x_done_r;
  logic                                y_done_r;
  logic                                t_done_r;
  logic [tct_pkg::ID_W-1:0]            id_r;

  logic                                out_valid_r;
  logic [tct_pkg::ID_W-1:0]            out_id_r;
  logic [1:0]                          out_state_r;
  logic signed [tct_pkg::COORD_W-1:0]  out_x_r;
  logic signed [tct_pkg::COORD_W-1:0]  out_y_r;

  // Configuration registers. They must be written only while the block is idle,
  // which the block itself does not enforce; the units sample them when an item starts.
  logic [tct_pkg::WIN_W-1:0]           win_w_r;
  logic [tct_pkg::WIN_W-1:0]           win_h_r;
  logic [tct_pkg::DEV_W-1:0]           dev_w_r;
  logic [tct_pkg::DEV_W-1:0]           dev_h_r;
  logic signed [tct_pkg::COORD_W-1:0]  org_x_r;
  logic signed [tct_pkg::COORD_W-1:0]  org_y_r;

  logic                                in_fire;
  logic                                all_done;
  logic                                out_free;
  logic signed [tct_pkg::COORD_W-1:0]  x_res;
  logic signed [tct_pkg::COORD_W-1:0]  y_res;
  tct_pkg::touch_state_t               t_res;
  tct_pkg::unit_status_t               x_st;
  tct_pkg::unit_status_t               y_st;
  tct_pkg::unit_status_t               t_st;

  // Every configuration beat is taken at once.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      win_w_r <= tct_pkg::WINDOW_WIDTH_RST;
      win_h_r <= tct_pkg::WINDOW_HEIGHT_RST;
      dev_w_r <= tct_pkg::DEVICE_WIDTH_RST;
      dev_h_r <= tct_pkg::DEVICE_HEIGHT_RST;
      org_x_r <= tct_pkg::ORIGIN_RST;
      org_y_r <= tct_pkg::ORIGIN_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        tct_pkg::CFG_WINDOW_WIDTH:  win_w_r <= cfg_data;
        tct_pkg::CFG_WINDOW_HEIGHT: win_h_r <= cfg_data;
        tct_pkg::CFG_DEVICE_WIDTH:  dev_w_r <= cfg_data[tct_pkg::DEV_W-1:0];
        tct_pkg::CFG_DEVICE_HEIGHT: dev_h_r <= cfg_data[tct_pkg::DEV_W-1:0];
        tct_pkg::CFG_ORIGIN_X:      org_x_r <= $signed(cfg_data);
        tct_pkg::CFG_ORIGIN_Y:      org_y_r <= $signed(cfg_data);
        default: ;
      endcase
    end
  end

  // A new beat is taken only when the engine and all of its units are free.
  // The output register is separate, so a result waiting downstream does not
  // stop the next item from starting.
  assign in_ready = (state_r == S_IDLE) && !x_st.busy && !y_st.busy && !t_st.busy;
  assign in_fire  = in_valid && in_ready;

  tct_coord_unit u_x (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (in_fire),
    .raw    (in_x_raw),
    .win    (win_w_r),
    .dev    (dev_w_r),
    .org    (org_x_r),
    .result (x_res),
    .status (x_st)
  );

  tct_coord_unit u_y (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (in_fire),
    .raw    (in_y_raw),
    .win    (win_h_r),
    .dev    (dev_h_r),
    .org    (org_y_r),
    .result (y_res),
    .status (y_st)
  );

  tct_contact_table #(
    .CONTACT_SLOTS (CONTACT_SLOTS)
  ) u_table (
    .clk         (clk),
    .rst_n       (rst_n),
    .start       (in_fire),
    .finger_id   (in_contact_id),
    .tip_down    (in_tip_down),
    .touch_state (t_res),
    .status      (t_st)
  );

  // Done pulses are collected, since the table finishes well before the
  // coordinate units do.
  assign all_done = (x_done_r || x_st.done) && (y_done_r || y_st.done)
                 && (t_done_r || t_st.done);
  assign out_free = !out_valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      x_done_r    <= 1'b0;
      y_done_r    <= 1'b0;
      t_done_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      // The output register empties when its beat is taken, unless the held
      // result moves in at the same edge.
      if (out_valid_r && out_ready && (state_r != S_HOLD)) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (in_fire) begin
            id_r     <= in_contact_id;
            x_done_r <= 1'b0;
            y_done_r <= 1'b0;
            t_done_r <= 1'b0;
            state_r  <= S_RUN;
          end
        end
        S_RUN: begin
          x_done_r <= x_done_r || x_st.done;
          y_done_r <= y_done_r || y_st.done;
          t_done_r <= t_done_r || t_st.done;
          if (all_done) begin
            state_r <= S_HOLD;
          end
        end
        S_HOLD: begin
          // The unit result registers stay put until the next start.
          if (out_free) begin
            out_valid_r <= 1'b1;
            out_id_r    <= id_r;
            out_state_r <= t_res;
            out_x_r     <= x_res;
            out_y_r     <= y_res;
            state_r     <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_valid       = out_valid_r;
  assign out_point_id    = out_id_r;
  assign out_touch_state = out_state_r;
  assign out_pos_x       = out_x_r;
  assign out_pos_y       = out_y_r;

endmodule

// File: src/tct_checker.sv
`include "touch_contact_tracker_core_defines.svh"

module tct_checker (
  input logic                                 clk,
  input logic                                 rst_n,
  input logic                                 in_valid,
  input logic                                 in_ready,
  input logic                                 out_valid,
  input logic                                 out_ready,
  input logic        [tct_pkg::ID_W-1:0]      out_point_id,
  input logic        [1:0]                    out_touch_state,
  input logic signed [tct_pkg::COORD_W-1:0]   out_pos_x,
  input logic signed [tct_pkg::COORD_W-1:0]   out_pos_y
);

  // A stalled result keeps its valid and its whole payload.
  `TCT_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(out_point_id) && $stable(out_touch_state) && $stable(out_pos_x) && $stable(out_pos_y), "stalled result changed")

  // Reset empties the output register.
  `TCT_ASSERT_NEXT_ALWAYS(a_reset_empty, clk, !rst_n, !out_valid, "result valid right after reset")

  // One item at a time: the block is busy right after it takes a beat.
  `TCT_ASSERT_NEXT(a_busy_after_accept, clk, rst_n, in_valid && in_ready, !in_ready, "input taken again right after a beat")

  // The serial arithmetic cannot produce a result in the cycle after a beat.
  `TCT_ASSERT_NEXT(a_no_early_result, clk, rst_n, in_valid && in_ready, !$rose(out_valid), "result appeared one cycle after a beat")

endmodule

bind touch_contact_tracker_core tct_checker u_tct_checker (.*);

// File: sim/tb_touch_contact_tracker_core.sv
module tb_touch_contact_tracker_core;

  localparam int unsigned SLOTS = tct_pkg::CONTACT_SLOTS_DEF;
  // The receiver's long hold-off, in cycles. It must be much longer than the
  // core's latency so that the core stalls its input while it is held off.
  localparam int LONG_HOLD = 600;
  // Cycles to watch for stray result beats after the last expected one.
  localparam int TAIL_CYCLES = 80;
  localparam int RANDOM_PHASES = 8;
  localparam int BEATS_PER_PHASE = 172;

  // One finger entry as the sender offers it. The drain_first flag makes the
  // sender wait until every expected point has come back before it offers
  // this beat.
  typedef struct {
    logic [tct_pkg::ID_W-1:0]           id;
    logic                               tip;
    logic signed [tct_pkg::COORD_W-1:0] x;
    logic signed [tct_pkg::COORD_W-1:0] y;
    bit                                 drain_first;
  } finger_beat_t;

  // One touch point as the core should report it.
  typedef struct {
    logic [tct_pkg::ID_W-1:0]           id;
    tct_pkg::touch_state_t              state;
    logic signed [tct_pkg::COORD_W-1:0] x;
    logic signed [tct_pkg::COORD_W-1:0] y;
  } touch_point_t;

  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  logic                               in_valid      = 1'b0;
  logic                               in_ready;
  logic [tct_pkg::ID_W-1:0]           in_contact_id = '0;
  logic                               in_tip_down   = 1'b0;
  logic signed [tct_pkg::COORD_W-1:0] in_x_raw      = '0;
  logic signed [tct_pkg::COORD_W-1:0] in_y_raw      = '0;

  logic                               out_valid;
  logic                               out_ready     = 1'b0;
  logic [tct_pkg::ID_W-1:0]           out_point_id;
  logic [1:0]                         out_touch_state;
  logic signed [tct_pkg::COORD_W-1:0] out_pos_x;
  logic signed [tct_pkg::COORD_W-1:0] out_pos_y;

  logic                               cfg_valid     = 1'b0;
  logic                               cfg_ready;
  logic [tct_pkg::CFG_IDX_W-1:0]      cfg_index     = '0;
  logic [tct_pkg::CFG_W-1:0]          cfg_data      = '0;

  touch_contact_tracker_core #(
    .CONTACT_SLOTS(SLOTS)
  ) dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_contact_id  (in_contact_id),
    .in_tip_down    (in_tip_down),
    .in_x_raw       (in_x_raw),
    .in_y_raw       (in_y_raw),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_point_id   (out_point_id),
    .out_touch_state(out_touch_state),
    .out_pos_x      (out_pos_x),
    .out_pos_y      (out_pos_y),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data)
  );

  always #5 clk = ~clk;

  // Shadow copy of the core's settings, at reset values. They change only
  // while the core is idle, so the driver can read them when a beat is taken.
  logic [tct_pkg::WIN_W-1:0]          win_w = tct_pkg::WINDOW_WIDTH_RST;
  logic [tct_pkg::WIN_W-1:0]          win_h = tct_pkg::WINDOW_HEIGHT_RST;
  logic [tct_pkg::DEV_W-1:0]          dev_w = tct_pkg::DEVICE_WIDTH_RST;
  logic [tct_pkg::DEV_W-1:0]          dev_h = tct_pkg::DEVICE_HEIGHT_RST;
  logic signed [tct_pkg::COORD_W-1:0] org_x = tct_pkg::ORIGIN_RST;
  logic signed [tct_pkg::COORD_W-1:0] org_y = tct_pkg::ORIGIN_RST;

  // Shadow contact table, cleared as the core clears its own at reset.
  bit                    seen_tbl  [SLOTS] = '{default: 1'b0};
  tct_pkg::touch_state_t state_tbl [SLOTS] = '{default: tct_pkg::TS_PRESSED};

  finger_beat_t pending_beats[$];
  touch_point_t expected_points[$];

  int n_errors         = 0;
  int n_beats_sent     = 0;
  int n_points_checked = 0;
  int n_cfg_writes     = 0;
  int stall_requests   = 0;
  bit sender_steady    = 1'b0;

  // Scale one raw coordinate into window space. The product is formed at full
  // width and divided with truncation toward zero; a zero device size gives a
  // scaled value of zero. The origin is subtracted and the sum wraps to 16 bits.
  function automatic logic signed [tct_pkg::COORD_W-1:0] scale_coord(
    logic signed [tct_pkg::COORD_W-1:0] raw,
    logic [tct_pkg::WIN_W-1:0]          win,
    logic [tct_pkg::DEV_W-1:0]          dev,
    logic signed [tct_pkg::COORD_W-1:0] org
  );
    longint scaled;
    scaled = 0;
    if (dev != '0) begin
      scaled = (longint'(raw) * longint'(win)) / longint'(dev);
    end
    return tct_pkg::COORD_W'(scaled - longint'(org));
  endfunction

  // Advance the shadow table by one finger entry and build the touch point
  // that the core should report for it.
  function automatic touch_point_t track_contact(finger_beat_t b);
    touch_point_t          p;
    int unsigned           slot;
    tct_pkg::touch_state_t next_state;
    slot = b.id % SLOTS;
    if (b.tip) begin
      if (!seen_tbl[slot]) begin
        next_state = tct_pkg::TS_PRESSED;
      end else begin
        case (state_tbl[slot])
          tct_pkg::TS_PRESSED:  next_state = tct_pkg::TS_MOVED;
          tct_pkg::TS_RELEASED: next_state = tct_pkg::TS_PRESSED;
          default:              next_state = tct_pkg::TS_MOVED;
        endcase
      end
    end else begin
      next_state = tct_pkg::TS_RELEASED;
    end
    seen_tbl[slot]  = 1'b1;
    state_tbl[slot] = next_state;
    p.id    = b.id;
    p.state = next_state;
    p.x     = scale_coord(b.x, win_w, dev_w, org_x);
    p.y     = scale_coord(b.y, win_h, dev_h, org_y);
    return p;
  endfunction

  // Driver. It keeps one beat on the input port until it is taken, and it
  // offers beats in bursts with gaps between them. At the edge that takes a
  // beat, the expected point is worked out and queued.
  finger_beat_t cur_beat;
  int burst_left = 1;
  int gap_left   = 0;

  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && in_ready) begin
        expected_points.insert(expected_points.size(), track_contact(cur_beat));
        n_beats_sent++;
      end
      // The port is free for a new beat when nothing is offered or the
      // offered beat was just taken.
      if (!in_valid || in_ready) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid <= 1'b0;
        end else if (pending_beats.size() > 0 &&
                     !(pending_beats[0].drain_first && expected_points.size() != 0)) begin
          cur_beat = pending_beats.pop_front();
          in_valid      <= 1'b1;
          in_contact_id <= cur_beat.id;
          in_tip_down   <= cur_beat.tip;
          in_x_raw      <= cur_beat.x;
          in_y_raw      <= cur_beat.y;
          burst_left--;
          if (burst_left <= 0) begin
            burst_left = $urandom_range(1, 24);
            if (sender_steady) begin
              gap_left = 0;
            end else if ($urandom_range(0, 3) == 0) begin
              // A long gap, so that gaps land on every step of the core's
              // serial multiply and divide.
              gap_left = $urandom_range(0, 70);
            end else begin
              gap_left = $urandom_range(0, 4);
            end
          end
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  task automatic compare_field(string name, logic [15:0] want, logic [15:0] got);
    if (want !== got) begin
      n_errors++;
      $display("%0t: %s mismatch: expected 0x%h, actual 0x%h", $time, name, want, got);
    end
  endtask

  // Monitor. Every result beat is checked field by field against the oldest
  // expected point. The same block drives out_ready: runs of ready and stall
  // of random length, now and then a long ready run with no stalls at all,
  // and a long hold-off whenever the stimulus asks for one.
  touch_point_t want_point;
  int  stalls_served = 0;
  int  hold_left     = 0;
  int  rdy_run       = 0;
  logic rdy_level    = 1'b1;

  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && out_ready) begin
        if (expected_points.size() == 0) begin
          n_errors++;
          $display("%0t: result beat with no expected point: expected none, actual id %0d",
                   $time, out_point_id);
        end else begin
          want_point = expected_points.pop_front();
          compare_field("point_id", 16'(want_point.id), 16'(out_point_id));
          compare_field("touch_state", 16'(want_point.state), 16'(out_touch_state));
          compare_field("pos_x", want_point.x, out_pos_x);
          compare_field("pos_y", want_point.y, out_pos_y);
          n_points_checked++;
        end
      end
      if (stalls_served != stall_requests) begin
        stalls_served = stall_requests;
        hold_left = LONG_HOLD;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else begin
        if (rdy_run == 0) begin
          if ($urandom_range(0, 7) == 0) begin
            rdy_level = 1'b1;
            rdy_run   = 200;
          end else begin
            rdy_level = ($urandom_range(0, 2) != 0);
            rdy_run   = rdy_level ? $urandom_range(1, 40) : $urandom_range(1, 30);
          end
        end
        rdy_run--;
        out_ready <= rdy_level;
      end
    end
  end

  // Write one configuration register and mirror it in the shadow settings.
  // The device sizes keep only their low 15 bits, as the core does.
  task automatic cfg_write(tct_pkg::cfg_index_t idx, logic [tct_pkg::CFG_W-1:0] data);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    n_cfg_writes++;
    case (idx)
      tct_pkg::CFG_WINDOW_WIDTH:  win_w = data;
      tct_pkg::CFG_WINDOW_HEIGHT: win_h = data;
      tct_pkg::CFG_DEVICE_WIDTH:  dev_w = data[tct_pkg::DEV_W-1:0];
      tct_pkg::CFG_DEVICE_HEIGHT: dev_h = data[tct_pkg::DEV_W-1:0];
      tct_pkg::CFG_ORIGIN_X:      org_x = data;
      tct_pkg::CFG_ORIGIN_Y:      org_y = data;
      default: ;
    endcase
  endtask

  task automatic apply_settings(logic [15:0] ww, logic [15:0] wh, logic [15:0] dw,
                                logic [15:0] dh, logic [15:0] ox, logic [15:0] oy);
    cfg_write(tct_pkg::CFG_WINDOW_WIDTH, ww);
    cfg_write(tct_pkg::CFG_WINDOW_HEIGHT, wh);
    cfg_write(tct_pkg::CFG_DEVICE_WIDTH, dw);
    cfg_write(tct_pkg::CFG_DEVICE_HEIGHT, dh);
    cfg_write(tct_pkg::CFG_ORIGIN_X, ox);
    cfg_write(tct_pkg::CFG_ORIGIN_Y, oy);
  endtask

  // Wait until every queued beat has been taken and every point has come back.
  // Each beat gives exactly one point, so the core is idle after this.
  task automatic wait_for_drain();
    while (pending_beats.size() != 0 || in_valid) @(posedge clk);
    while (expected_points.size() != 0) @(posedge clk);
    @(posedge clk);
  endtask

  task automatic queue_beat(int id, bit tip, logic [15:0] x, logic [15:0] y);
    finger_beat_t b;
    b.id          = tct_pkg::ID_W'(id);
    b.tip         = tip;
    b.x           = x;
    b.y           = y;
    b.drain_first = 1'b0;
    pending_beats.insert(pending_beats.size(), b);
  endtask

  // Often one of the two ends of a range, otherwise a value from anywhere inside it.
  function automatic logic [15:0] pick_range(int unsigned lo, int unsigned hi);
    int unsigned r;
    r = $urandom_range(0, 9);
    if (r < 2) return 16'(lo);
    if (r < 4) return 16'(hi);
    return 16'($urandom_range(lo, hi));
  endfunction

  function automatic logic [15:0] pick_coord();
    case ($urandom_range(0, 19))
      0:       return 16'h8000;
      1:       return 16'h7fff;
      2:       return 16'h0000;
      3:       return 16'hffff;
      default: return 16'($urandom_range(0, 65535));
    endcase
  endfunction

  // Random settings for one phase. Now and then a size is zero, and the top
  // bit of a device size write is random, since the core must drop it.
  task automatic apply_random_settings();
    logic [15:0] ww, wh, dw, dh, ox, oy;
    ww = ($urandom_range(0, 15) == 0) ? 16'h0000 : pick_range(1, 65535);
    wh = ($urandom_range(0, 15) == 0) ? 16'h0000 : pick_range(1, 65535);
    dw = {1'($urandom_range(0, 1)), 15'(pick_range(1, 32767))};
    dh = {1'($urandom_range(0, 1)), 15'(pick_range(1, 32767))};
    if ($urandom_range(0, 15) == 0) dw[14:0] = '0;
    if ($urandom_range(0, 15) == 0) dh[14:0] = '0;
    ox = pick_range(0, 65535) ^ 16'h8000;
    oy = pick_range(0, 65535) ^ 16'h8000;
    apply_settings(ww, wh, dw, dh, ox, oy);
  endtask

  // One phase of random beats. Most beats follow a small pool of contacts
  // through press, move and release, so that every state change is reached;
  // the rest use any id and any tip value.
  task automatic queue_random_phase(int count);
    int pool [6];
    finger_beat_t b;
    foreach (pool[k]) pool[k] = $urandom_range(0, 255);
    for (int n = 0; n < count; n++) begin
      if ($urandom_range(0, 9) == 0) begin
        b.id  = tct_pkg::ID_W'($urandom_range(0, 255));
        b.tip = 1'($urandom_range(0, 1));
      end else begin
        b.id  = tct_pkg::ID_W'(pool[$urandom_range(0, 5)]);
        b.tip = ($urandom_range(0, 3) != 0);
      end
      b.x           = pick_coord();
      b.y           = pick_coord();
      b.drain_first = ($urandom_range(0, 49) == 0);
      pending_beats.insert(pending_beats.size(), b);
    end
  endtask

  initial begin
    int tail;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed beats at the reset settings: one contact walks through every
    // touch state, including a press after release, and a contact that is
    // first seen with its tip up. Coordinates hit both ends of their range.
    queue_beat(0, 1'b1, 16'h0000, 16'h0000);
    queue_beat(0, 1'b1, 16'h7fff, 16'h8000);
    queue_beat(0, 1'b1, 16'h8000, 16'h7fff);
    queue_beat(0, 1'b0, 16'hffff, 16'hffff);
    queue_beat(0, 1'b1, 16'h0001, 16'h0001);
    queue_beat(0, 1'b0, 16'h1234, 16'hedcb);
    queue_beat(255, 1'b0, 16'h7fff, 16'h7fff);
    queue_beat(255, 1'b1, 16'h8000, 16'h8000);
    queue_beat(255, 1'b1, 16'h4000, 16'hc000);
    queue_beat(170, 1'b1, 16'h5555, 16'haaaa);
    queue_beat(85, 1'b0, 16'haaaa, 16'h5555);
    wait_for_drain();

    // Largest scale and origins at both ends, so the wrap to 16 bits shows.
    apply_settings(16'hffff, 16'hffff, 16'h0001, 16'h0001, 16'h8000, 16'h7fff);
    queue_beat(1, 1'b1, 16'h7fff, 16'h8000);
    queue_beat(1, 1'b1, 16'h8000, 16'h7fff);
    queue_beat(2, 1'b1, 16'hffff, 16'h0001);
    queue_beat(1, 1'b0, 16'h0000, 16'h0000);
    queue_beat(254, 1'b1, 16'h0001, 16'hffff);
    queue_beat(2, 1'b0, 16'h7ffe, 16'h8001);
    wait_for_drain();

    // A zero window width on x and a zero device height on y. The device
    // height write has only its dropped top bit set.
    apply_settings(16'h0000, 16'hffff, 16'h7fff, 16'h8000, 16'h0001, 16'hffff);
    queue_beat(3, 1'b1, 16'h7fff, 16'h7fff);
    queue_beat(3, 1'b1, 16'h8000, 16'h8000);
    queue_beat(4, 1'b0, 16'h1357, 16'h9bdf);
    queue_beat(3, 1'b0, 16'hffff, 16'h0000);
    wait_for_drain();

    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      apply_random_settings();
      if (ph == 3) begin
        // The receiver holds off for a long stretch while the sender keeps
        // offering beats back to back, so the core fills and stalls its input.
        sender_steady = 1'b1;
        stall_requests++;
      end
      queue_random_phase(BEATS_PER_PHASE);
      wait_for_drain();
      sender_steady = 1'b0;
    end

    // Back to the reset settings for the last check of all registers.
    apply_settings(tct_pkg::WINDOW_WIDTH_RST, tct_pkg::WINDOW_HEIGHT_RST,
                   16'(tct_pkg::DEVICE_WIDTH_RST), 16'(tct_pkg::DEVICE_HEIGHT_RST),
                   tct_pkg::ORIGIN_RST, tct_pkg::ORIGIN_RST);
    queue_random_phase(40);
    wait_for_drain();

    // Watch a while longer for result beats that nothing asked for.
    tail = 0;
    while (tail < TAIL_CYCLES) begin
      @(posedge clk);
      tail++;
    end
    if (expected_points.size() != 0) begin
      n_errors++;
      $display("%0t: points left over: expected 0, actual %0d", $time,
               expected_points.size());
    end

    $display("Sent %0d finger beats and checked %0d touch points over %0d register writes,",
             n_beats_sent, n_points_checked, n_cfg_writes);
    $display("covering every touch state change, zero sizes and coordinate wrap.");
    if (n_errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  // Watchdog for a core that hangs on either handshake.
  initial begin
    #12000000;
    $display("Timeout waiting for the core to finish.");
    $display("Test completed with failures");
    $finish;
  end

endmodule
